FILE: design/ntfsdr_pkg.sv
// Shared constants for the run list decoder: register indexes, reset values, parse phases, widths.
`default_nettype none

package ntfsdr_pkg;

    // Configuration register indexes
    localparam logic CFG_CLUSTER_SECTORS = 1'b0;
    localparam logic CFG_VOLUME_START    = 1'b1;

    // Configuration reset values
    localparam logic [7:0]  CLUSTER_SECTORS_RST = 8'd8;
    localparam logic [47:0] VOLUME_START_RST    = 48'd0;

    // Parse phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;

    // Byte and result widths fixed by the run list format
    localparam int BYTE_W   = 8;
    localparam int SECT_W   = 48;
    localparam int OFFSET_W = 64;
    localparam int PROD_W   = OFFSET_W + BYTE_W;

endpackage

`default_nettype wire

FILE: design/ntfs_data_run_decoder_unit.sv
// Run list decoder: parses run list bytes and emits one sector-addressed result per run, end or bad header.
`default_nettype none

// The decoder takes one run list byte per cycle and keeps up with a byte in every cycle,
// with no gaps between runs or between lists. A header byte opens a run (length size in
// the low nibble, offset size in the high nibble); when the last field byte arrives the
// offset delta is folded into the running cluster offset and the result leaves through the
// stage 1 register, then the offset magnitude, cluster multiply and volume add/saturate stages.
// A zero header gives an end-of-list result and clears the running offset; a header
// nibble above MAX_FIELD_BYTES gives a bad_header result. Each pipeline stage fills a
// bubble on its own, so input is held off only when every stage holds a result and the output
// is stalled. Write configuration only while no run is in flight; the block does not enforce it.
module ntfs_data_run_decoder_unit #(
    parameter int MAX_FIELD_BYTES = 8,
    parameter int SECTOR_BITS     = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [ntfsdr_pkg::SECT_W-1:0] cfg_data,
    // run list byte stream
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ntfsdr_pkg::BYTE_W-1:0] run_byte,
    // run results
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ntfsdr_pkg::SECT_W-1:0]      run_start_sector,
    output logic [ntfsdr_pkg::SECT_W-1:0]      run_sector_count,
    output logic                               list_end,
    output logic                               bad_header
);

    import ntfsdr_pkg::*;

    localparam int DW  = BYTE_W * MAX_FIELD_BYTES;                 // field accumulator width
    localparam int CW  = $clog2(MAX_FIELD_BYTES + 1);              // bytes-left counter width
    localparam int PW  = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;
    localparam int CPW = DW + BYTE_W;                              // count product width
    localparam logic [PROD_W-1:0] SecMax = (PROD_W'(1) << SECTOR_BITS) - PROD_W'(1);

    // Configuration registers
    logic [BYTE_W-1:0] cluster_sectors_reg;
    logic [SECT_W-1:0] volume_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_sectors_reg <= CLUSTER_SECTORS_RST;
            volume_start_reg    <= VOLUME_START_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLUSTER_SECTORS: cluster_sectors_reg <= cfg_data[BYTE_W-1:0];
                CFG_VOLUME_START:    volume_start_reg    <= cfg_data;
                default:             cluster_sectors_reg <= cluster_sectors_reg;
            endcase
        end
    end

    // Pipeline flow control: each stage loads when it is empty or its successor loads
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic out_load, s3_load, s2_load, s1_load, in_take;

    assign out_load = !out_valid_reg || !out_stall;
    assign s3_load  = !s3_valid_reg || out_load;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;
    assign in_take  = in_valid && s1_load;

    // Parser state
    logic [1:0]          phase_reg, phase_next;
    logic [CW-1:0]       len_left_reg, len_left_next;
    logic [CW-1:0]       off_left_reg, off_left_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [DW-1:0]       len_acc_reg, len_acc_next;
    logic [DW-1:0]       dlt_acc_reg, dlt_acc_next;
    logic [OFFSET_W-1:0] run_off_reg, run_off_next;

    // Parser outputs toward stage 1
    logic                res_valid, res_end, res_bad;
    logic [DW-1:0]       res_len;
    logic [OFFSET_W-1:0] res_off;

    // Field bytes merged in at the current byte position
    logic [DW-1:0]       len_upd, dlt_upd;
    logic [OFFSET_W-1:0] dlt_pad, delta64;
    logic                sign_ext;
    logic [3:0]          nib_lo, nib_hi;

    always_comb
    begin
        len_upd = len_acc_reg;
        dlt_upd = dlt_acc_reg;
        for (int k = 0; k < MAX_FIELD_BYTES; k++)
        begin
            if (pos_reg == PW'(k))
            begin
                len_upd[BYTE_W*k +: BYTE_W] = run_byte;
                dlt_upd[BYTE_W*k +: BYTE_W] = run_byte;
            end
        end
    end

    // Offset delta: sign-extended from its top byte only while the running offset is nonzero
    always_comb
    begin
        sign_ext = run_byte[BYTE_W-1] && (run_off_reg != '0);
        dlt_pad  = OFFSET_W'(dlt_upd);
        for (int k = 0; k < OFFSET_W / BYTE_W; k++)
        begin
            if (k <= int'(pos_reg))
                delta64[BYTE_W*k +: BYTE_W] = dlt_pad[BYTE_W*k +: BYTE_W];
            else
                delta64[BYTE_W*k +: BYTE_W] = {BYTE_W{sign_ext}};
        end
    end

    assign nib_lo = run_byte[3:0];
    assign nib_hi = run_byte[7:4];

    // Parse one byte
    always_comb
    begin
        phase_next    = phase_reg;
        len_left_next = len_left_reg;
        off_left_next = off_left_reg;
        pos_next      = pos_reg;
        len_acc_next  = len_acc_reg;
        dlt_acc_next  = dlt_acc_reg;
        run_off_next  = run_off_reg;
        res_valid     = 1'b0;
        res_end       = 1'b0;
        res_bad       = 1'b0;
        res_len       = len_upd;
        res_off       = run_off_reg;

        unique case (phase_reg)
            PH_LENGTH:
            begin
                len_acc_next  = len_upd;
                pos_next      = PW'(pos_reg + 1'b1);
                len_left_next = CW'(len_left_reg - 1'b1);
                if (len_left_reg == CW'(1))
                begin
                    pos_next = '0;
                    if (off_left_reg == '0)
                    begin
                        // run with no offset field: delta is zero
                        res_valid  = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET:
            begin
                dlt_acc_next  = dlt_upd;
                pos_next      = PW'(pos_reg + 1'b1);
                off_left_next = CW'(off_left_reg - 1'b1);
                if (off_left_reg == CW'(1))
                begin
                    run_off_next = run_off_reg + delta64;
                    res_off      = run_off_next;
                    res_len      = len_acc_reg;
                    res_valid    = 1'b1;
                    phase_next   = PH_HEADER;
                    pos_next     = '0;
                end
            end
            default:
            begin
                // header byte (unused phase code is taken as header too)
                phase_next = PH_HEADER;
                pos_next   = '0;
                if (run_byte == '0)
                begin
                    run_off_next  = '0;
                    len_left_next = '0;
                    off_left_next = '0;
                    res_valid     = 1'b1;
                    res_end       = 1'b1;
                end
                else if (int'(nib_lo) > MAX_FIELD_BYTES || int'(nib_hi) > MAX_FIELD_BYTES)
                begin
                    len_left_next = '0;
                    off_left_next = '0;
                    res_valid     = 1'b1;
                    res_bad       = 1'b1;
                end
                else
                begin
                    len_left_next = nib_lo[CW-1:0];
                    off_left_next = nib_hi[CW-1:0];
                    len_acc_next  = '0;
                    dlt_acc_next  = '0;
                    phase_next    = (nib_lo != '0) ? PH_LENGTH : PH_OFFSET;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            len_left_reg <= '0;
            off_left_reg <= '0;
            pos_reg      <= '0;
            len_acc_reg  <= '0;
            dlt_acc_reg  <= '0;
            run_off_reg  <= '0;
        end
        else if (in_take)
        begin
            phase_reg    <= phase_next;
            len_left_reg <= len_left_next;
            off_left_reg <= off_left_next;
            pos_reg      <= pos_next;
            len_acc_reg  <= len_acc_next;
            dlt_acc_reg  <= dlt_acc_next;
            run_off_reg  <= run_off_next;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_take && res_valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
            if (s3_load)
                s3_valid_reg <= s2_valid_reg;
            if (out_load)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: new running offset and run length
    logic                s1_end_reg, s1_bad_reg;
    logic [DW-1:0]       s1_len_reg;
    logic [OFFSET_W-1:0] s1_off_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_end_reg <= res_end;
            s1_bad_reg <= res_bad;
            s1_len_reg <= res_len;
            s1_off_reg <= res_off;
        end
    end

    // Stage 2: offset sign and magnitude
    logic                s2_end_reg, s2_bad_reg, s2_neg_reg;
    logic [DW-1:0]       s2_len_reg;
    logic [OFFSET_W-1:0] s2_mag_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_end_reg <= s1_end_reg;
            s2_bad_reg <= s1_bad_reg;
            s2_neg_reg <= s1_off_reg[OFFSET_W-1];
            s2_len_reg <= s1_len_reg;
            s2_mag_reg <= s1_off_reg[OFFSET_W-1] ? (OFFSET_W'(0) - s1_off_reg) : s1_off_reg;
        end
    end

    // Stage 3: cluster size products
    logic              s3_end_reg, s3_bad_reg, s3_neg_reg;
    logic [PROD_W-1:0] s3_start_prod_reg;
    logic [CPW-1:0]    s3_cnt_prod_reg;

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_end_reg        <= s2_end_reg;
            s3_bad_reg        <= s2_bad_reg;
            s3_neg_reg        <= s2_neg_reg;
            s3_start_prod_reg <= PROD_W'(s2_mag_reg) * PROD_W'(cluster_sectors_reg);
            s3_cnt_prod_reg   <= CPW'(s2_len_reg) * CPW'(cluster_sectors_reg);
        end
    end

    // Output stage: saturate products, apply volume start, saturate again
    logic [PROD_W-1:0] start_prod_sat, cnt_prod_ext, cnt_sat, vol_ext, start_raw, start_sat;

    always_comb
    begin
        vol_ext        = PROD_W'(volume_start_reg);
        start_prod_sat = (s3_start_prod_reg > SecMax) ? SecMax : s3_start_prod_reg;
        cnt_prod_ext   = PROD_W'(s3_cnt_prod_reg);
        cnt_sat        = (cnt_prod_ext > SecMax) ? SecMax : cnt_prod_ext;
        if (s3_neg_reg)
            start_raw = (start_prod_sat >= vol_ext) ? '0 : (vol_ext - start_prod_sat);
        else
            start_raw = vol_ext + start_prod_sat;
        start_sat = (start_raw > SecMax) ? SecMax : start_raw;
    end

    logic [SECT_W-1:0] start_out_reg, count_out_reg;
    logic              end_out_reg, bad_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_load && s3_valid_reg)
        begin
            end_out_reg <= s3_end_reg;
            bad_out_reg <= s3_bad_reg;
            if (s3_end_reg || s3_bad_reg)
            begin
                start_out_reg <= '0;
                count_out_reg <= '0;
            end
            else
            begin
                start_out_reg <= start_sat[SECT_W-1:0];
                count_out_reg <= cnt_sat[SECT_W-1:0];
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign run_start_sector = start_out_reg;
    assign run_sector_count = count_out_reg;
    assign list_end         = end_out_reg;
    assign bad_header       = bad_out_reg;

endmodule

`default_nettype wire
